// ===== hdl/ecu_pkg.sv =====
// Shared types, constants, tables and rounding helpers for the easing curve unit.
package ecu_pkg;

  localparam int FRAC = 16;
  localparam int ONE  = 1 << FRAC;
  localparam int HALF = 1 << (FRAC - 1);

  localparam logic signed [19:0] ONE_S  = 20'sd65536;
  localparam logic signed [18:0] OFF_B1 = 19'sd49152;  // 3/4
  localparam logic signed [18:0] OFF_B2 = 19'sd61440;  // 15/16
  localparam logic signed [18:0] OFF_B3 = 19'sd64512;  // 63/64

  // Register index decoded from paddr[2].
  localparam logic REG_MODE = 1'b0;

  typedef enum logic [3:0] {
    MODE_LINEAR       = 4'd0,
    MODE_QUAD_IN      = 4'd1,
    MODE_QUAD_OUT     = 4'd2,
    MODE_QUAD_INOUT   = 4'd3,
    MODE_QUAD_IN_B    = 4'd4,
    MODE_QUAD_OUT_B   = 4'd5,
    MODE_QUAD_INOUT_B = 4'd6,
    MODE_CUBIC_IN     = 4'd7,
    MODE_CUBIC_OUT    = 4'd8,
    MODE_CUBIC_INOUT  = 4'd9,
    MODE_ELASTIC_IN   = 4'd10,
    MODE_ELASTIC_OUT  = 4'd11,
    MODE_BOUNCE_IN    = 4'd12,
    MODE_BOUNCE_OUT   = 4'd13,
    MODE_PASS_A       = 4'd14,
    MODE_PASS_B       = 4'd15
  } easing_mode_e;

  // Final combine: val = (p << scl) + off; result = neg ? base - val : val.
  typedef struct packed {
    logic [1:0]         scl;
    logic               neg;
    logic               base_one;
    logic signed [18:0] off;
  } fin_t;

  typedef struct packed {
    fin_t               fin;
    logic               elastic;
    logic signed [19:0] a;
    logic signed [19:0] b;
    logic signed [19:0] c;
    logic [4:0]         sh1;
    logic               mul2;
    logic [4:0]         exp_idx;
    logic [11:0]        exp_rem;
    logic [3:0]         k;
    logic [4:0]         cos_idx;
    logic [10:0]        cos_rem;
    logic               cos_neg;
  } s1_t;

  typedef struct packed {
    fin_t               fin;
    logic               elastic;
    logic signed [19:0] p1;
    logic signed [19:0] c;
    logic               mul2;
    logic [17:0]        ev;
    logic [3:0]         k;
    logic [16:0]        cv;
    logic               cos_neg;
  } s2_t;

  typedef struct packed {
    fin_t               fin;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic               use_mul;
  } s3_t;

  typedef struct packed {
    fin_t               fin;
    logic signed [19:0] p2;
  } s4_t;

  // Quarter sine wave, Q16, 17 points.
  function automatic logic [16:0] sin_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd6424;
      5'd2:  v = 17'd12785;
      5'd3:  v = 17'd19024;
      5'd4:  v = 17'd25080;
      5'd5:  v = 17'd30893;
      5'd6:  v = 17'd36410;
      5'd7:  v = 17'd41576;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd50660;
      5'd10: v = 17'd54491;
      5'd11: v = 17'd57798;
      5'd12: v = 17'd60547;
      5'd13: v = 17'd62714;
      5'd14: v = 17'd64277;
      5'd15: v = 17'd65220;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  // 2^x over one octave, Q16, 17 points.
  function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
    logic [17:0] v;
    case (idx)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

  // Shift right by s (s >= 1), rounding half away from zero.
  function automatic logic signed [19:0] rnd_shift(input logic signed [39:0] x,
                                                   input logic [4:0] s);
    logic [39:0]        m;
    logic [39:0]        r;
    logic signed [19:0] mag;
    m   = x[39] ? 40'(-x) : 40'(x);
    r   = (m + (40'd1 << (s - 5'd1))) >> s;
    mag = signed'(r[19:0]);
    return x[39] ? -mag : mag;
  endfunction

endpackage

// ===== hdl/easing_curve_unit.sv =====
// Top level of the easing curve unit: register port, pipeline and output stage.
//
// The unit maps a progress value t (unsigned, 16 fraction bits, 65536 = 1.0,
// larger values clamp to 1.0) to an eased value (signed, 16 fraction bits)
// through the curve chosen in the easing_mode register at byte address 0.
// Input requests arrive on in_valid_i / progress_i and are taken at a clock
// edge where in_valid_i is high and in_stall_o is low. Results leave on
// out_valid_o / eased_value_o and are taken when out_stall_i is low.
// The datapath is a five stage pipeline: operand setup, first product with
// table interpolation, envelope shift, second product, and final combine
// with saturation into the output register. One request is taken every
// cycle while the receiver is not stalling the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises in the same cycle, so nothing is dropped or repeated.
// Reset clears all valid bits and sets the curve to linear. The mode
// register should only be written while the pipeline is empty.
module easing_curve_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [16:0]        progress_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] eased_value_o
);
  import ecu_pkg::*;

  easing_mode_e       mode_q;
  logic               adv;
  logic               s1_valid;
  s1_t                s1_op;
  logic               s4_valid;
  s4_t                s4_res;
  logic               out_valid_q;
  logic signed [17:0] eased_d, eased_q;
  logic signed [22:0] val;
  logic signed [23:0] res;

  // The whole pipeline advances unless a finished result is being held.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_MODE) ? {28'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
      mode_q <= easing_mode_e'(pwdata[3:0]);
    end
  end

  ecu_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .valid_i    (in_valid_i),
    .progress_i (progress_i),
    .mode_i     (mode_q),
    .valid_o    (s1_valid),
    .op_o       (s1_op)
  );

  ecu_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s1_valid),
    .op_i    (s1_op),
    .valid_o (s4_valid),
    .res_o   (s4_res)
  );

  // Final combine: scale, offset, optional reflection, then saturation.
  always_comb begin
    val = (23'(s4_res.p2) <<< s4_res.fin.scl) + 23'(s4_res.fin.off);
    if (s4_res.fin.neg) begin
      res = (s4_res.fin.base_one ? 24'sd65536 : 24'sd0) - 24'(val);
    end else begin
      res = 24'(val);
    end
    if (res < -24'sd65536) begin
      eased_d = -18'sd65536;
    end else if (res > 24'sd131071) begin
      eased_d = 18'sd131071;
    end else begin
      eased_d = res[17:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      eased_q <= eased_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign eased_value_o = eased_q;

`ifndef SYNTHESIS
  a_hold_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(s1_valid) && $stable(s4_valid)))
    else $error("pipeline moved while the output was stalled");

  a_mode_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite) |=> $stable(mode_q))
    else $error("mode register changed without a write");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (eased_value_o >= -18'sd65536))
    else $error("eased value below the saturation floor");
`endif

endmodule

// ===== hdl/ecu_decode.sv =====
// First pipeline stage: clamps progress and sets up the operands for the chosen curve.
module ecu_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [16:0]          progress_i,
  input  ecu_pkg::easing_mode_e mode_i,
  output logic                 valid_o,
  output ecu_pkg::s1_t         op_o
);
  import ecu_pkg::*;

  logic               valid_q;
  s1_t                op_d, op_q;
  logic [16:0]        tc;
  logic signed [19:0] ts;
  logic [16:0]        sb;
  logic [19:0]        e;
  logic [19:0]        m;
  logic [16:0]        g;
  logic [19:0]        ph;
  logic [16:0]        p;
  logic [15:0]        pos;
  logic signed [20:0] e_s;
  logic signed [19:0] bv;
  logic [4:0]         bsh;
  logic signed [18:0] boff;

  always_comb begin
    tc  = (progress_i > 17'(ONE)) ? 17'(ONE) : progress_i;
    ts  = signed'({3'b000, tc});
    sb  = (mode_i == MODE_BOUNCE_IN) ? 17'(ONE) - tc : tc;
    e   = ({3'b000, sb} << 3) + ({3'b000, sb} << 1) + {3'b000, sb};
    e_s = signed'({1'b0, e});
    if (e < 20'(4 * ONE)) begin
      bv = 20'(e_s);  bsh = 5'd20;  boff = 19'sd0;
    end else if (e < 20'(8 * ONE)) begin
      bv = 20'(e_s - 21'sd393216);  bsh = 5'd20;  boff = OFF_B1;
    end else if (e < 20'(10 * ONE)) begin
      bv = 20'(e_s - 21'sd589824);  bsh = 5'd20;  boff = OFF_B2;
    end else begin
      bv = 20'((e_s <<< 1) - 21'sd1376256);  bsh = 5'd22;  boff = OFF_B3;
    end

    // Elastic envelope exponent and cosine phase.
    m  = (mode_i == MODE_ELASTIC_IN) ? 20'(17'(ONE) - tc) * 20'd10 : 20'(tc) * 20'd10;
    g  = 17'(ONE) - {1'b0, m[15:0]};
    ph = 20'(tc) * 20'd5 + 20'(HALF);
    p  = ph[16:0];
    pos = p[15] ? 16'(HALF) - {1'b0, p[14:0]} : {1'b0, p[14:0]};

    op_d          = '0;
    op_d.a        = ts;
    op_d.b        = ONE_S;
    op_d.sh1      = 5'd16;
    op_d.exp_idx  = g[16:12];
    op_d.exp_rem  = g[11:0];
    op_d.k        = m[19:16];
    op_d.cos_idx  = pos[15:11];
    op_d.cos_rem  = pos[10:0];
    op_d.cos_neg  = p[16];

    unique case (mode_i)
      MODE_QUAD_IN, MODE_QUAD_IN_B: begin
        op_d.b = ts;
      end
      MODE_QUAD_OUT, MODE_QUAD_OUT_B: begin
        op_d.b = (ONE_S <<< 1) - ts;
      end
      MODE_QUAD_INOUT, MODE_QUAD_INOUT_B: begin
        if (tc < 17'(HALF)) begin
          op_d.b       = ts;
          op_d.fin.scl = 2'd1;
        end else begin
          op_d.a       = (ONE_S <<< 2) - (ts <<< 1);
          op_d.b       = ts;
          op_d.fin.off = -19'sd65536;
        end
      end
      MODE_CUBIC_IN: begin
        op_d.b    = ts;
        op_d.c    = ts;
        op_d.mul2 = 1'b1;
      end
      MODE_CUBIC_OUT: begin
        op_d.a       = ts - ONE_S;
        op_d.b       = ts - ONE_S;
        op_d.c       = ts - ONE_S;
        op_d.mul2    = 1'b1;
        op_d.fin.off = 19'sd65536;
      end
      MODE_CUBIC_INOUT: begin
        op_d.mul2 = 1'b1;
        if (tc < 17'(HALF)) begin
          op_d.b       = ts;
          op_d.c       = ts;
          op_d.fin.scl = 2'd2;
        end else begin
          op_d.a       = ts - ONE_S;
          op_d.b       = (ts <<< 1) - (ONE_S <<< 1);
          op_d.c       = (ts <<< 1) - (ONE_S <<< 1);
          op_d.fin.off = 19'sd65536;
        end
      end
      MODE_ELASTIC_IN, MODE_ELASTIC_OUT: begin
        // The end points pass t through unchanged.
        if (tc != 17'd0 && tc != 17'(ONE)) begin
          op_d.elastic      = 1'b1;
          op_d.fin.neg      = 1'b1;
          op_d.fin.base_one = (mode_i == MODE_ELASTIC_OUT);
        end
      end
      MODE_BOUNCE_IN, MODE_BOUNCE_OUT: begin
        op_d.a            = bv;
        op_d.b            = bv;
        op_d.sh1          = bsh;
        op_d.fin.off      = boff;
        op_d.fin.neg      = (mode_i == MODE_BOUNCE_IN);
        op_d.fin.base_one = (mode_i == MODE_BOUNCE_IN);
      end
      MODE_LINEAR, MODE_PASS_A, MODE_PASS_B: begin
        op_d.b = ONE_S;
      end
      default: begin
        op_d.b = ONE_S;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op_q <= op_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

// ===== hdl/ecu_core.sv =====
// Arithmetic stages: first product and table interpolation, envelope shift, second product.
module ecu_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         adv_i,
  input  logic         valid_i,
  input  ecu_pkg::s1_t op_i,
  output logic         valid_o,
  output ecu_pkg::s4_t res_o
);
  import ecu_pkg::*;

  logic [2:0]         valid_q;
  s2_t                s2_d, s2_q;
  s3_t                s3_d, s3_q;
  s4_t                s4_d, s4_q;
  logic signed [39:0] prod1;
  logic signed [39:0] prod2;
  logic [17:0]        e_base, e_diff;
  logic [29:0]        e_dr;
  logic [16:0]        c_base, c_diff;
  logic [27:0]        c_dr;
  logic [17:0]        env;

  // Stage 2: first product, and both table interpolations.
  always_comb begin
    prod1  = op_i.a * op_i.b;
    e_base = exp2_tab(op_i.exp_idx);
    e_diff = exp2_tab(op_i.exp_idx + 5'd1) - e_base;
    e_dr   = e_diff * op_i.exp_rem;
    c_base = sin_tab(op_i.cos_idx);
    c_diff = sin_tab(op_i.cos_idx + 5'd1) - c_base;
    c_dr   = c_diff * op_i.cos_rem;

    s2_d         = '0;
    s2_d.fin     = op_i.fin;
    s2_d.elastic = op_i.elastic;
    s2_d.p1      = rnd_shift(prod1, op_i.sh1);
    s2_d.c       = op_i.c;
    s2_d.mul2    = op_i.mul2;
    s2_d.ev      = e_base + 18'((e_dr + 30'd2048) >> 12);
    s2_d.k       = op_i.k;
    s2_d.cv      = c_base + 17'((c_dr + 28'd1024) >> 11);
    s2_d.cos_neg = op_i.cos_neg;
  end

  // Stage 3: scale the envelope by 2^-(k+1) and sign the cosine.
  always_comb begin
    env      = (s2_q.ev + (18'd1 << s2_q.k)) >> (s2_q.k + 4'd1);
    s3_d.fin = s2_q.fin;
    if (s2_q.elastic) begin
      s3_d.x       = signed'({2'b00, env});
      s3_d.y       = s2_q.cos_neg ? -signed'({3'b000, s2_q.cv}) : signed'({3'b000, s2_q.cv});
      s3_d.use_mul = 1'b1;
    end else begin
      s3_d.x       = s2_q.p1;
      s3_d.y       = s2_q.c;
      s3_d.use_mul = s2_q.mul2;
    end
  end

  // Stage 4: second product, shared by cubic and elastic curves.
  always_comb begin
    prod2    = s3_q.x * s3_q.y;
    s4_d.fin = s3_q.fin;
    s4_d.p2  = s3_q.use_mul ? rnd_shift(prod2, 5'd16) : s3_q.x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign valid_o = valid_q[2];
  assign res_o   = s4_q;

endmodule
